// File: hw/rtl/wsdf_pkg.sv
package wsdf_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 64;
  localparam logic [31:0] MAX_LEN_RESET   = 32'd1048576;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT_LEFT16 = 3'd1;
  localparam logic [2:0] EXT_LEFT64 = 3'd7;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_CLOSE     = 3'd1,
    KIND_PING      = 3'd2,
    KIND_PONG      = 3'd3,
    KIND_TOO_LARGE = 3'd4
  } kind_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] data_byte;
    logic       last;
  } res_t;

endpackage

// File: hw/rtl/websocket_frame_deframer.sv
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    in_rx_byte[7:0]
// out       out  out_valid/out_stall  out_kind[2:0], out_data_byte[7:0], out_last
// cfg       in   cfg_valid/cfg_ready  cfg_max_payload_len[31:0]
//
// one byte per cycle while in_stall is low; a result appears in the cycle after its item is taken
// synchronous active-low reset: header phase, limit back to 1 MiB, no result held
// in_stall follows out_stall only while a result is held in the output register
// cfg_ready is always high
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_payload_len
);

  logic           acc;
  logic [31:0]    max_len_r;
  wsdf_pkg::res_t core_res;
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     kind_r;
  logic [7:0]     data_r;
  logic           last_r;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  wsdf_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (acc),
    .rx_byte (in_rx_byte),
    .max_len (max_len_r),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wsdf_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_payload_len;
    end
  end

  always_comb begin
    if (acc && core_res.vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && core_res.vld) begin
      kind_r <= core_res.kind;
      data_r <= core_res.data_byte;
      last_r <= core_res.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_data_byte = data_r;
  assign out_last      = last_r;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    acc && core_res.vld |=> out_valid_r)
    else $error("result of accepted item not held");

  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r != wsdf_pkg::KIND_DATA) |-> (data_r == 8'd0) && !last_r)
    else $error("event result carries data or last");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(acc) && !$past(out_valid_r) |-> !out_valid_r)
    else $error("result without accepted item");

endmodule

// File: hw/rtl/wsdf_core.sv
module wsdf_core #(
  parameter int unsigned LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         max_len,
  output wsdf_pkg::res_t      res
);

  localparam int unsigned CmpW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  wsdf_pkg::phase_t       phase_r, phase_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   mask_present_r, mask_present_nxt;
  logic                   discard_r, discard_nxt;
  logic [2:0]             ext_left_r, ext_left_nxt;
  logic [LENGTH_BITS-1:0] br_r, br_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             idx_r, idx_nxt;

  logic                   is_ctrl;
  logic                   is_ext;
  logic [LENGTH_BITS-1:0] len_short;
  logic [LENGTH_BITS-1:0] len_ext;
  logic [LENGTH_BITS-1:0] br_dec;
  logic                   finish;
  logic [LENGTH_BITS-1:0] fin_len;
  logic                   disc_in;
  logic                   too_large;
  logic                   fin_zero;
  wsdf_pkg::phase_t       fin_phase;
  logic [7:0]             key_byte;
  wsdf_pkg::kind_t        ctrl_kind;

  assign is_ctrl   = (opcode_r == wsdf_pkg::OP_CLOSE) || (opcode_r == wsdf_pkg::OP_PING) ||
                     (opcode_r == wsdf_pkg::OP_PONG);
  assign is_ext    = (rx_byte[6:0] == wsdf_pkg::LEN_EXT16) ||
                     (rx_byte[6:0] == wsdf_pkg::LEN_EXT64);
  assign len_short = LENGTH_BITS'(rx_byte[6:0]);
  assign len_ext   = {br_r[LENGTH_BITS-9:0], rx_byte};
  assign br_dec    = (br_r == '0) ? br_r : br_r - LENGTH_BITS'(1);

  // header completion point
  always_comb begin
    finish  = 1'b0;
    fin_len = br_r;
    disc_in = discard_r;
    case (phase_r)
      wsdf_pkg::PH_HDR1: begin
        disc_in = is_ctrl;
        fin_len = len_short;
        finish  = !is_ext && !rx_byte[7];
      end
      wsdf_pkg::PH_EXT: begin
        fin_len = len_ext;
        finish  = (ext_left_r == 3'd0) && !mask_present_r;
      end
      wsdf_pkg::PH_MASK: begin
        finish = (idx_r == 2'd3);
      end
      default: begin
      end
    endcase
  end

  assign too_large = finish && !disc_in && (CmpW'(fin_len) > CmpW'(max_len));
  assign fin_zero  = (fin_len == '0);
  assign fin_phase = fin_zero ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_DATA;

  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    case (opcode_r)
      wsdf_pkg::OP_CLOSE: ctrl_kind = wsdf_pkg::KIND_CLOSE;
      wsdf_pkg::OP_PING:  ctrl_kind = wsdf_pkg::KIND_PING;
      default:            ctrl_kind = wsdf_pkg::KIND_PONG;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      wsdf_pkg::PH_HDR1: begin
        if (is_ext) begin
          phase_nxt = wsdf_pkg::PH_EXT;
        end else if (rx_byte[7]) begin
          phase_nxt = wsdf_pkg::PH_MASK;
        end else begin
          phase_nxt = fin_phase;
        end
      end
      wsdf_pkg::PH_EXT: begin
        if (ext_left_r == 3'd0) begin
          phase_nxt = mask_present_r ? wsdf_pkg::PH_MASK : fin_phase;
        end
      end
      wsdf_pkg::PH_MASK: begin
        if (idx_r == 2'd3) begin
          phase_nxt = fin_phase;
        end
      end
      wsdf_pkg::PH_DATA: begin
        if (br_dec == '0) begin
          phase_nxt = wsdf_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_nxt = wsdf_pkg::PH_HDR1;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    opcode_nxt       = opcode_r;
    mask_present_nxt = mask_present_r;
    discard_nxt      = discard_r;
    ext_left_nxt     = ext_left_r;
    br_nxt           = br_r;
    key_nxt          = key_r;
    idx_nxt          = idx_r;
    res              = '{vld: 1'b0, kind: wsdf_pkg::KIND_DATA, data_byte: 8'd0, last: 1'b0};
    case (phase_r)
      wsdf_pkg::PH_HDR1: begin
        mask_present_nxt = rx_byte[7];
        key_nxt          = 32'd0;
        idx_nxt          = 2'd0;
        discard_nxt      = is_ctrl;
        if (is_ctrl) begin
          res.vld  = 1'b1;
          res.kind = ctrl_kind;
        end
        if (is_ext) begin
          br_nxt       = '0;
          ext_left_nxt = (rx_byte[6:0] == wsdf_pkg::LEN_EXT16) ? wsdf_pkg::EXT_LEFT16
                                                                : wsdf_pkg::EXT_LEFT64;
        end else begin
          br_nxt = len_short;
        end
      end
      wsdf_pkg::PH_EXT: begin
        br_nxt = len_ext;
        if (ext_left_r != 3'd0) begin
          ext_left_nxt = ext_left_r - 3'd1;
        end
      end
      wsdf_pkg::PH_MASK: begin
        key_nxt = {key_r[23:0], rx_byte};
        idx_nxt = idx_r + 2'd1;
      end
      wsdf_pkg::PH_DATA: begin
        idx_nxt = idx_r + 2'd1;
        br_nxt  = br_dec;
        if (!discard_r) begin
          res.vld       = 1'b1;
          res.kind      = wsdf_pkg::KIND_DATA;
          res.data_byte = rx_byte ^ key_byte;
          res.last      = (br_dec == '0);
        end
      end
      default: begin
        opcode_nxt = rx_byte[3:0];
      end
    endcase
    if (finish) begin
      idx_nxt = 2'd0;
      if (too_large) begin
        discard_nxt = 1'b1;
        res.vld     = 1'b1;
        res.kind    = wsdf_pkg::KIND_TOO_LARGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= wsdf_pkg::PH_HDR0;
      opcode_r       <= 4'd0;
      mask_present_r <= 1'b0;
      discard_r      <= 1'b0;
      ext_left_r     <= 3'd0;
      br_r           <= '0;
      key_r          <= 32'd0;
      idx_r          <= 2'd0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      opcode_r       <= opcode_nxt;
      mask_present_r <= mask_present_nxt;
      discard_r      <= discard_nxt;
      ext_left_r     <= ext_left_nxt;
      br_r           <= br_nxt;
      key_r          <= key_nxt;
      idx_r          <= idx_nxt;
    end
  end

endmodule
